FILE: design/fdli_pkg.sv
// Shared constants for the feedback delay line with interpolated read.
`timescale 1ns / 1ps

package fdli_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_DELAY_WHOLE    = 2'd0;
    localparam logic [1:0] REG_DELAY_FRACTION = 2'd1;
    localparam logic [1:0] REG_FEEDBACK_GAIN  = 2'd2;
    localparam logic [1:0] REG_WET_LEVEL      = 2'd3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int WHOLE_BITS     = 17;
    localparam int FRAC_BITS      = 16;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_DATA_BITS  = 17;

    // 1.0 in 0.16 fraction weight (17 bits) and in Q1.15
    localparam logic [FRAC_BITS:0]   FRAC_ONE = 17'h10000;
    localparam logic [GAIN_BITS-1:0] Q15_ONE  = 16'h8000;

endpackage

FILE: design/fdli_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module fdli_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/feedback_delay_line_interp.sv
// Feedback delay line with linearly interpolated two-tap read and wet/dry mix.
`timescale 1ns / 1ps

//  channel  | ports                                  | moves
//  ---------+----------------------------------------+---------------------------
//  input    | s_valid, s_ready, s_sample_in          | one audio sample request
//  result   | m_valid, m_ready, m_sample_out         | one mixed sample request
//  config   | cfg_wr_en, cfg_index, cfg_data         | register write, no wait
//
//  The path from accept to the result register: two reads of the single-read-port
//  delay RAM, then registered multiplies (interpolation, feedback, mix) in turn;
//  s_ready returns once the result register is loaded, so a new request waits for the last.
//  After reset a clearing pass zeroes all DEPTH entries, one per cycle, while s_ready
//  stays low; config writes are taken meanwhile.
//  A result waiting on m_ready holds only the last step of the next request.

module feedback_delay_line_interp #(
    parameter int DEPTH       = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input samples
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_in,
    // output samples
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [fdli_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fdli_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(DEPTH);
    localparam int PW  = SB + 18;   // interpolation products
    localparam int GW  = SB + 17;   // feedback product
    localparam int MW  = SB + 18;   // mix product
    localparam int MSW = SB + 19;   // mix sum
    localparam int FB  = fdli_pkg::FRAC_BITS;
    localparam int GB  = fdli_pkg::GAIN_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD0    = 4'd1;
    localparam logic [3:0] S_RD1    = 4'd2;
    localparam logic [3:0] S_MUL0   = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_INTERP = 4'd5;
    localparam logic [3:0] S_GAIN   = 4'd6;
    localparam logic [3:0] S_STORE  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // ---------------- configuration registers ----------------
    logic [fdli_pkg::WHOLE_BITS-1:0] delay_whole_reg;
    logic [FB-1:0]                   delay_fraction_reg;
    logic [GB-1:0]                   feedback_gain_reg;
    logic [GB-1:0]                   wet_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_whole_reg    <= '0;
            delay_fraction_reg <= '0;
            feedback_gain_reg  <= '0;
            wet_level_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fdli_pkg::REG_DELAY_WHOLE:    delay_whole_reg    <= cfg_data;
                fdli_pkg::REG_DELAY_FRACTION: delay_fraction_reg <= cfg_data[FB-1:0];
                fdli_pkg::REG_FEEDBACK_GAIN:  feedback_gain_reg  <= cfg_data[GB-1:0];
                fdli_pkg::REG_WET_LEVEL:      wet_level_reg      <= cfg_data[GB-1:0];
                default: ;
            endcase
        end
    end

    // gains above unity clamp to unity
    logic [GB-1:0] gain_c, wet_c;
    assign gain_c = (feedback_gain_reg > fdli_pkg::Q15_ONE) ? fdli_pkg::Q15_ONE
                                                            : feedback_gain_reg;
    assign wet_c  = (wet_level_reg > fdli_pkg::Q15_ONE) ? fdli_pkg::Q15_ONE
                                                        : wet_level_reg;

    // ---------------- control and datapath registers ----------------
    logic [3:0]              state_reg, state_next;
    logic                    clr_busy_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic                    m_valid_reg, m_valid_next;

    logic [AW-1:0]           i0_reg, i1_reg;
    logic                    zero_whole_reg;
    logic signed [SB-1:0]    x_reg, t0_reg, t1_reg, y_reg;
    logic signed [PW-1:0]    p0_reg, p1_reg;
    logic signed [GW-1:0]    pg_reg;
    logic signed [MW-1:0]    pm_reg;
    logic signed [SB-1:0]    m_sample_out_reg;

    // RAM
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic signed [SB-1:0]    ram_wdata, ram_rdata;

    fdli_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // saturate to SB signed bits
    function automatic logic signed [SB-1:0] sat_fn(input logic signed [SB+3:0] v);
        logic signed [SB+3:0] vmax, vmin;
        vmax = $signed({{5{1'b0}}, {(SB-1){1'b1}}});
        vmin = $signed({{5{1'b1}}, {(SB-1){1'b0}}});
        if (v > vmax) begin
            sat_fn = vmax[SB-1:0];
        end else if (v < vmin) begin
            sat_fn = vmin[SB-1:0];
        end else begin
            sat_fn = v[SB-1:0];
        end
    endfunction

    // ---------------- tap addresses ----------------
    // delay clamped to DEPTH-1, newest tap at wp - d, older tap one before
    logic [AW-1:0] d_eff, i0_calc, i1_calc;
    logic [AW:0]   wp_diff;

    always_comb begin
        if (32'(delay_whole_reg) > 32'(DEPTH - 1)) begin
            d_eff = AW'(DEPTH - 1);
        end else begin
            d_eff = AW'(delay_whole_reg);
        end
        wp_diff = {1'b0, wp_reg} - {1'b0, d_eff};
        if (wp_diff[AW]) begin
            i0_calc = wp_diff[AW-1:0] + AW'(DEPTH);
        end else begin
            i0_calc = wp_diff[AW-1:0];
        end
        if (i0_reg == '0) begin
            i1_calc = AW'(DEPTH - 1);
        end else begin
            i1_calc = i0_reg - AW'(1);
        end
    end

    // ---------------- arithmetic ----------------
    logic [FB:0]            w0;
    logic signed [PW-1:0]   p0_calc, p1_calc;
    logic signed [PW:0]     interp_sum;
    logic signed [SB-1:0]   y_calc;
    logic signed [GW-1:0]   pg_calc, pg_round;
    logic signed [SB+3:0]   store_sum;
    logic signed [SB-1:0]   store_val;
    logic signed [SB:0]     diff_yx;
    logic signed [MW-1:0]   pm_calc;
    logic signed [MSW-1:0]  mix_sum, mix_sh;
    logic signed [SB-1:0]   mix_val;
    logic                   zero_total;

    always_comb begin
        w0      = fdli_pkg::FRAC_ONE - {1'b0, delay_fraction_reg};
        p0_calc = PW'(t0_reg) * PW'($signed({1'b0, w0}));
        p1_calc = PW'(t1_reg) * PW'($signed({2'b00, delay_fraction_reg}));

        // round half up, then drop 16 fraction bits
        interp_sum = (PW+1)'(p0_reg) + (PW+1)'(p1_reg) + (PW+1)'(32768);
        zero_total = zero_whole_reg && (delay_fraction_reg == '0);
        y_calc     = zero_total ? x_reg : interp_sum[SB+15:16];

        pg_calc   = GW'(y_reg) * GW'($signed({1'b0, gain_c}));
        pg_round  = (pg_reg + GW'(16384)) >>> 15;
        store_sum = (SB+4)'(x_reg) + pg_round[SB+3:0];
        store_val = sat_fn(store_sum);

        // wet*y + (1-wet)*x == wet*(y-x) + x
        diff_yx = (SB+1)'(y_reg) - (SB+1)'(x_reg);
        pm_calc = MW'(diff_yx) * MW'($signed({1'b0, wet_c}));
        mix_sum = MSW'(pm_reg) + (MSW'(x_reg) <<< 15) + MSW'(16384);
        mix_sh  = mix_sum >>> 15;
        mix_val = sat_fn(mix_sh[SB+3:0]);
    end

    // ---------------- sequencer ----------------
    logic accept_in, load_out;

    assign s_ready   = (state_reg == S_IDLE) && !clr_busy_reg;
    assign accept_in = s_valid && s_ready;
    assign load_out  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept_in) state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_MUL0;
            S_MUL0:   state_next = S_MUL1;
            S_MUL1:   state_next = S_INTERP;
            S_INTERP: state_next = S_GAIN;
            S_GAIN:   state_next = S_STORE;
            S_STORE:  state_next = S_OUT;
            S_OUT:    if (load_out) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        wp_next = wp_reg;
        if (load_out) begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        end
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // RAM port control: clearing pass owns the write port after reset
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = store_val;
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (state_reg == S_STORE) begin
            ram_we = 1'b1;
        end
        ram_raddr = (state_reg == S_RD0) ? i0_reg : i1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            x_reg          <= s_sample_in;
            i0_reg         <= i0_calc;
            zero_whole_reg <= (d_eff == '0);
        end
        if (state_reg == S_RD0) begin
            i1_reg <= i1_calc;
        end
        if (state_reg == S_RD1) begin
            t0_reg <= zero_whole_reg ? x_reg : ram_rdata;   // newest tap
        end
        if (state_reg == S_MUL0) begin
            t1_reg <= ram_rdata;                            // older tap
            p0_reg <= p0_calc;
        end
        if (state_reg == S_MUL1) begin
            p1_reg <= p1_calc;
        end
        if (state_reg == S_INTERP) begin
            y_reg <= y_calc;
        end
        if (state_reg == S_GAIN) begin
            pg_reg <= pg_calc;
        end
        if (state_reg == S_STORE) begin
            pm_reg <= pm_calc;
        end
        if (load_out) begin
            m_sample_out_reg <= mix_val;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

endmodule
